### hdl/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types, codes and helpers of the timer table.
// ----------------------------------------------------------------------------
package mtt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TICK_UNIT  = 1;
    localparam int IDX_W      = $clog2(NUM_TIMERS);
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam logic [7:0] EARLY_RESET = 8'd20;

    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_KILL = 2'd1;
    localparam logic [1:0] OP_ALL  = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_REP = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOT_FND  = 2'd3;

    typedef struct packed {
        logic       in_ready;
        logic       latch;
        logic       clr_count;
        logic       idx_clr;
        logic       idx_tick;
        logic       idx_inc;
        logic       idx_dec;
        logic       write_entry;
        logic       k_init;
        logic       shift_step;
        logic       count_dec;
        logic       tick_dec;
        logic       tick_fire;
        logic       set_resp;
        logic [1:0] resp_code;
        logic       out_resp;
        logic       out_flush;
    } mtt_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       zero_rep;
        logic       count_zero;
        logic       at_end;
        logic       full;
        logic       id_match;
        logic       idx_zero;
        logic       shift_done;
        logic       left_gt1;
        logic       fire_drop;
        logic       pend_valid;
        logic       out_free;
    } mtt_sts_t;

    function automatic logic [23:0] mtt_reload(input logic [23:0] period,
                                               input logic [15:0] repeats,
                                               input logic        rep_forever,
                                               input logic [7:0]  early);
        logic [33:0] cut;
        logic [33:0] per;
        logic [33:0] diff;
        logic [23:0] res;
        cut  = 34'(TICK_UNIT) * {26'd0, early};
        per  = {10'd0, period};
        diff = per - cut;
        res  = period;
        if (!rep_forever && repeats == 16'd1) begin
            if (per > cut && diff > 34'(TICK_UNIT)) begin
                res = diff[23:0];
            end else begin
                res = 24'(TICK_UNIT);
            end
        end
        return res;
    endfunction

endpackage

### hdl/mtt_ctrl.sv
// ----------------------------------------------------------------------------
// mtt_ctrl
// Sequencer of the timer table: search, rearm, removal and tick walk.
// ----------------------------------------------------------------------------
module mtt_ctrl import mtt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  mtt_sts_t sts,
    output mtt_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;
    localparam logic [2:0] S_TICK  = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                unique case (sts.op)
                    OP_SET, OP_KILL: begin
                        if (sts.op == OP_SET && sts.zero_rep) begin
                            cmd.set_resp  = 1'b1;
                            cmd.resp_code = ST_ZERO_REP;
                            state_next    = S_RESP;
                        end else begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_SRCH;
                        end
                    end
                    OP_ALL: begin
                        cmd.clr_count = 1'b1;
                        cmd.set_resp  = 1'b1;
                        cmd.resp_code = ST_OK;
                        state_next    = S_RESP;
                    end
                    default: begin
                        if (sts.count_zero) begin
                            state_next = S_IDLE;
                        end else begin
                            cmd.idx_tick = 1'b1;
                            state_next   = S_TICK;
                        end
                    end
                endcase
            end
            S_SRCH: begin
                priority if (sts.at_end) begin
                    cmd.set_resp = 1'b1;
                    state_next   = S_RESP;
                    priority if (sts.op == OP_KILL) begin
                        cmd.resp_code = ST_NOT_FND;
                    end else if (sts.full) begin
                        cmd.resp_code = ST_FULL;
                    end else begin
                        cmd.resp_code   = ST_OK;
                        cmd.write_entry = 1'b1;
                    end
                end else if (sts.id_match) begin
                    cmd.set_resp  = 1'b1;
                    cmd.resp_code = ST_OK;
                    if (sts.op == OP_SET) begin
                        cmd.write_entry = 1'b1;
                        state_next      = S_RESP;
                    end else begin
                        cmd.k_init = 1'b1;
                        state_next = S_SHIFT;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SHIFT: begin
                if (sts.shift_done) begin
                    cmd.count_dec = 1'b1;
                    if (sts.op == OP_TICK) begin
                        if (sts.idx_zero) begin
                            state_next = S_FLUSH;
                        end else begin
                            cmd.idx_dec = 1'b1;
                            state_next  = S_TICK;
                        end
                    end else begin
                        state_next = S_RESP;
                    end
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.out_resp = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_TICK: begin
                priority if (sts.left_gt1) begin
                    cmd.tick_dec = 1'b1;
                    if (sts.idx_zero) begin
                        state_next = S_FLUSH;
                    end else begin
                        cmd.idx_dec = 1'b1;
                    end
                end else if (sts.pend_valid && !sts.out_free) begin
                    state_next = S_TICK;
                end else begin
                    cmd.tick_fire = 1'b1;
                    priority if (sts.fire_drop) begin
                        cmd.k_init = 1'b1;
                        state_next = S_SHIFT;
                    end else if (sts.idx_zero) begin
                        state_next = S_FLUSH;
                    end else begin
                        cmd.idx_dec = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                priority if (!sts.pend_valid) begin
                    state_next = S_IDLE;
                end else if (sts.out_free) begin
                    cmd.out_flush = 1'b1;
                    state_next    = S_IDLE;
                end else begin
                    state_next = S_FLUSH;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/mtt_dp.sv
// ----------------------------------------------------------------------------
// mtt_dp
// Timer table storage, walk counters, pending fire event and result register.
// ----------------------------------------------------------------------------
module mtt_dp import mtt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  mtt_cmd_t    cmd,
    output mtt_sts_t    sts,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic [1:0]  s_op,
    input  logic [15:0] s_timer_id,
    input  logic [23:0] s_elapse_ticks,
    input  logic [15:0] s_repeat_count,
    input  logic        s_repeat_forever,
    input  logic [31:0] s_bind_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [1:0]  m_status,
    output logic [15:0] m_fired_id,
    output logic [31:0] m_fired_value,
    output logic        m_last
);

    logic [15:0] slot_id_reg      [NUM_TIMERS];
    logic [31:0] slot_value_reg   [NUM_TIMERS];
    logic [23:0] slot_period_reg  [NUM_TIMERS];
    logic [23:0] slot_left_reg    [NUM_TIMERS];
    logic [15:0] slot_repeats_reg [NUM_TIMERS];
    logic        slot_forever_reg [NUM_TIMERS];

    logic [7:0]       early_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [IDX_W-1:0] k_reg;
    logic [1:0]       op_reg;
    logic [15:0]      id_reg;
    logic [23:0]      per_reg;
    logic [15:0]      rep_reg;
    logic             fev_reg;
    logic [31:0]      val_reg;
    logic [1:0]       resp_reg;
    logic             pend_valid_reg;
    logic [15:0]      pend_id_reg;
    logic [31:0]      pend_value_reg;
    logic             m_valid_reg;
    logic             m_kind_reg;
    logic [1:0]       m_status_reg;
    logic [15:0]      m_id_reg;
    logic [31:0]      m_value_reg;
    logic             m_last_reg;

    logic [IDX_W-1:0] ix;
    logic [IDX_W-1:0] kn;
    logic [15:0]      cur_rep;
    logic [15:0]      new_rep;
    logic [23:0]      per_fix;
    logic             out_free;
    logic             push_pend;

    assign ix       = idx_reg[IDX_W-1:0];
    assign kn       = k_reg + 1'b1;
    assign cur_rep  = slot_repeats_reg[ix];
    assign new_rep  = (cur_rep != 16'd0) ? cur_rep - 16'd1 : cur_rep;
    assign per_fix  = (per_reg == 24'd0) ? 24'd1 : per_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign push_pend = cmd.tick_fire && pend_valid_reg;

    assign sts.op         = op_reg;
    assign sts.zero_rep   = !fev_reg && rep_reg == 16'd0;
    assign sts.count_zero = count_reg == '0;
    assign sts.at_end     = idx_reg == count_reg;
    assign sts.full       = count_reg == CNT_W'(NUM_TIMERS);
    assign sts.id_match   = slot_id_reg[ix] == id_reg;
    assign sts.idx_zero   = idx_reg == '0;
    assign sts.shift_done = ({1'b0, k_reg} + 1'b1) >= count_reg;
    assign sts.left_gt1   = slot_left_reg[ix] > 24'(TICK_UNIT);
    assign sts.fire_drop  = !slot_forever_reg[ix] && new_rep == 16'd0;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            early_reg      <= EARLY_RESET;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                early_reg <= cfg_wr_data;
            end
            if (cmd.clr_count) begin
                count_reg <= '0;
            end else if (cmd.write_entry && idx_reg == count_reg) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.count_dec) begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.tick_fire) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.out_flush || cmd.latch) begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.out_resp || cmd.out_flush || push_pend) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg  <= s_op;
            id_reg  <= s_timer_id;
            per_reg <= s_elapse_ticks;
            rep_reg <= s_repeat_count;
            fev_reg <= s_repeat_forever;
            val_reg <= s_bind_value;
        end
        if (cmd.set_resp) begin
            resp_reg <= cmd.resp_code;
        end
        priority if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_tick) begin
            idx_reg <= count_reg - 1'b1;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_reg - 1'b1;
        end else begin
            idx_reg <= idx_reg;
        end
        if (cmd.k_init) begin
            k_reg <= ix;
        end else if (cmd.shift_step) begin
            k_reg <= kn;
        end
        if (cmd.tick_fire) begin
            pend_id_reg    <= slot_id_reg[ix];
            pend_value_reg <= slot_value_reg[ix];
        end
        priority if (cmd.out_resp) begin
            m_kind_reg   <= 1'b0;
            m_status_reg <= resp_reg;
            m_id_reg     <= 16'd0;
            m_value_reg  <= 32'd0;
            m_last_reg   <= 1'b1;
        end else if (cmd.out_flush || push_pend) begin
            m_kind_reg   <= 1'b1;
            m_status_reg <= ST_OK;
            m_id_reg     <= pend_id_reg;
            m_value_reg  <= pend_value_reg;
            m_last_reg   <= cmd.out_flush;
        end else begin
            m_kind_reg   <= m_kind_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_entry) begin
            slot_id_reg[ix]      <= id_reg;
            slot_value_reg[ix]   <= val_reg;
            slot_period_reg[ix]  <= per_fix;
            slot_repeats_reg[ix] <= fev_reg ? 16'd0 : rep_reg;
            slot_forever_reg[ix] <= fev_reg;
            slot_left_reg[ix]    <= mtt_reload(per_fix, rep_reg, fev_reg, early_reg);
        end else if (cmd.shift_step) begin
            slot_id_reg[k_reg]      <= slot_id_reg[kn];
            slot_value_reg[k_reg]   <= slot_value_reg[kn];
            slot_period_reg[k_reg]  <= slot_period_reg[kn];
            slot_left_reg[k_reg]    <= slot_left_reg[kn];
            slot_repeats_reg[k_reg] <= slot_repeats_reg[kn];
            slot_forever_reg[k_reg] <= slot_forever_reg[kn];
        end else if (cmd.tick_dec) begin
            slot_left_reg[ix] <= slot_left_reg[ix] - 24'(TICK_UNIT);
        end else if (cmd.tick_fire) begin
            if (!slot_forever_reg[ix]) begin
                slot_repeats_reg[ix] <= new_rep;
            end
            slot_left_reg[ix] <= mtt_reload(slot_period_reg[ix], new_rep,
                                            slot_forever_reg[ix], early_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_status      = m_status_reg;
    assign m_fired_id    = m_id_reg;
    assign m_fired_value = m_value_reg;
    assign m_last        = m_last_reg;

endmodule

### hdl/multi_timer_table.sv
// ----------------------------------------------------------------------------
// multi_timer_table
// Table of up to 16 software timers with set, kill, kill-all and tick.
// ----------------------------------------------------------------------------
// One request is handled at a time. Kill-all empties the list without a walk. Set
// and kill search the list one entry per cycle, and a kill then shifts the
// newer entries down to close the gap in the list. A tick walks the list newest
// to oldest, one entry per cycle while no fire event is held up by a stalled
// consumer, and each timer that expires for good has the newer entries shifted
// down over it. Fire events leave through a one-entry result register and a
// one-entry pending buffer, so a stalled consumer only holds the walk when both
// are full. The table takes one write per cycle, but it is read at the walk
// index and, while shifting, at the next entry as well.
// ----------------------------------------------------------------------------
module multi_timer_table import mtt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [15:0] s_timer_id,
    input  logic [23:0] s_elapse_ticks,
    input  logic [15:0] s_repeat_count,
    input  logic        s_repeat_forever,
    input  logic [31:0] s_bind_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [1:0]  m_status,
    output logic [15:0] m_fired_id,
    output logic [31:0] m_fired_value,
    output logic        m_last
);

    mtt_cmd_t cmd;
    mtt_sts_t sts;

    mtt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .sts     (sts),
        .cmd     (cmd)
    );

    mtt_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_op             (s_op),
        .s_timer_id       (s_timer_id),
        .s_elapse_ticks   (s_elapse_ticks),
        .s_repeat_count   (s_repeat_count),
        .s_repeat_forever (s_repeat_forever),
        .s_bind_value     (s_bind_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_status         (m_status),
        .m_fired_id       (m_fired_id),
        .m_fired_value    (m_fired_value),
        .m_last           (m_last)
    );

    assign s_ready = cmd.in_ready;

endmodule

### hdl/mtt_checker.sv
// ----------------------------------------------------------------------------
// mtt_checker
// Port-level checks of the timer table results.
// ----------------------------------------------------------------------------
module mtt_checker import mtt_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_kind,
    input logic [1:0]  m_status,
    input logic [15:0] m_fired_id,
    input logic [31:0] m_fired_value
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_fire_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind |-> m_status == ST_OK)
        else $error("fire event with nonzero status");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_kind |-> m_fired_id == 16'd0 && m_fired_value == 32'd0)
        else $error("status result carries timer data");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fired_id))
        else $error("result dropped while stalled");

endmodule

bind multi_timer_table mtt_checker u_mtt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_kind        (m_kind),
    .m_status      (m_status),
    .m_fired_id    (m_fired_id),
    .m_fired_value (m_fired_value)
);
